### design/assert_macros.svh
// Assertion macros for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low
`define SRM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define SRM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/srm_pkg.sv
// Package: sizes, types and register indexes for the spiral-order matrix reader
package srm_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = 7;
  localparam int DIM_W       = 4;
  localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DATA_W      = 32;
  localparam int CFG_IDX_W   = 2;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  localparam cfg_idx_t CFG_ROW_COUNT    = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_COLUMN_COUNT = cfg_idx_t'(1);

  // Zero reads as one, anything above the maximum saturates
  function automatic dim_t clamp_dim(input dim_t v, input dim_t maxv);
    dim_t res;
    if (v == dim_t'(0)) begin
      res = dim_t'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### design/spiral_order_matrix_reader.sv
// Spiral-order matrix reader: loads a matrix row-major, replays it in clockwise spiral order
//
// Input: one element per transaction, taken on a rising edge with start high and busy low.
//   Elements arrive in row-major order; the store address is the load count.
// Config: cfg_valid/cfg_ready write channel, index 0 = row_count, index 1 = column_count,
//   4-bit values; 0 is used as 1 and values above 8 saturate. cfg_ready is always high.
//   Higher indexes are ignored. Write only while busy is low.
// Loading: one element per cycle, no result for elements that do not complete the matrix.
// Run: the element completing the matrix raises busy. The spiral sequencer issues one
//   store read per cycle; the store registers the read data and out_valid is registered
//   beside it, so the first strobe follows the state register and the read register. Then
//   one result per cycle, rows*columns results in all, the last flagged by out_run_last.
//   busy drops the cycle after it. Load and replay move one element at a time, through
//   the single write port during the load and the single read port during the run.
// Output: out_valid is a one-cycle strobe; the receiver cannot stall.
// Reset (rst_n low, synchronous): load count zero, sizes 1x1, sequencer idle. The store
//   contents are not cleared; every entry is written before it is read.
module spiral_order_matrix_reader (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  srm_pkg::word_t          in_element_value,
  output logic                    out_valid,
  output srm_pkg::word_t          out_spiral_value,
  output logic                    out_run_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  srm_pkg::cfg_idx_t       cfg_index,
  input  srm_pkg::dim_t           cfg_data
);
  import srm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RIGHT = 5'b00010,
    ST_DOWN  = 5'b00100,
    ST_LEFT  = 5'b01000,
    ST_UP    = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  dim_t               row_count_r, column_count_r;
  logic [CNT_W-1:0]   load_cnt_r, load_cnt_nxt;
  logic [ROW_W-1:0]   top_r, top_nxt, bottom_r, bottom_nxt, row_r, row_nxt;
  logic [COL_W-1:0]   left_r, left_nxt, right_r, right_nxt, col_r, col_nxt;
  dim_t               run_cols_r, run_cols_nxt;
  logic               rd_vld_r, rd_last_r;

  dim_t               rows, cols;
  logic [CNT_W-1:0]   total, load_inc, addr_prod;
  logic               accept, complete;
  logic               issue, last;
  logic [ROW_W-1:0]   rd_row;
  logic [COL_W-1:0]   rd_col;
  logic [DATA_W-1:0]  rdata;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != ST_IDLE) || rd_vld_r;
  assign accept    = start && !busy;

  assign rows     = clamp_dim(row_count_r, dim_t'(MAX_ROWS));
  assign cols     = clamp_dim(column_count_r, dim_t'(MAX_COLS));
  assign total    = CNT_W'(rows) * CNT_W'(cols);
  assign load_inc = load_cnt_r + CNT_W'(1);
  assign complete = load_inc >= total;

  // Sequencer walks one edge per state; bounds shrink as each edge finishes
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    top_nxt      = top_r;
    bottom_nxt   = bottom_r;
    left_nxt     = left_r;
    right_nxt    = right_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    run_cols_nxt = run_cols_r;
    issue        = 1'b0;
    last         = 1'b0;
    rd_row       = row_r;
    rd_col       = col_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (complete) begin
            load_cnt_nxt = '0;
            top_nxt      = '0;
            left_nxt     = '0;
            bottom_nxt   = ROW_W'(rows - dim_t'(1));
            right_nxt    = COL_W'(cols - dim_t'(1));
            col_nxt      = '0;
            run_cols_nxt = cols;
            state_nxt    = ST_RIGHT;
          end else begin
            load_cnt_nxt = load_inc;
          end
        end
      end
      ST_RIGHT: begin
        issue  = 1'b1;
        rd_row = top_r;
        rd_col = col_r;
        if (col_r == right_r) begin
          top_nxt = top_r + ROW_W'(1);
          if (top_r == bottom_r) begin
            last      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            row_nxt   = top_r + ROW_W'(1);
            state_nxt = ST_DOWN;
          end
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      ST_DOWN: begin
        issue  = 1'b1;
        rd_row = row_r;
        rd_col = right_r;
        if (row_r == bottom_r) begin
          right_nxt = right_r - COL_W'(1);
          if (right_r == left_r) begin
            last      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            col_nxt   = right_r - COL_W'(1);
            state_nxt = ST_LEFT;
          end
        end else begin
          row_nxt = row_r + ROW_W'(1);
        end
      end
      ST_LEFT: begin
        issue  = 1'b1;
        rd_row = bottom_r;
        rd_col = col_r;
        if (col_r == left_r) begin
          bottom_nxt = bottom_r - ROW_W'(1);
          if (bottom_r == top_r) begin
            last      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            row_nxt   = bottom_r - ROW_W'(1);
            state_nxt = ST_UP;
          end
        end else begin
          col_nxt = col_r - COL_W'(1);
        end
      end
      ST_UP: begin
        issue  = 1'b1;
        rd_row = row_r;
        rd_col = left_r;
        if (row_r == top_r) begin
          left_nxt = left_r + COL_W'(1);
          if (left_r == right_r) begin
            last      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            col_nxt   = left_r + COL_W'(1);
            state_nxt = ST_RIGHT;
          end
        end else begin
          row_nxt = row_r - ROW_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign addr_prod = CNT_W'(rd_row) * CNT_W'(run_cols_r) + CNT_W'(rd_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      load_cnt_r     <= '0;
      row_count_r    <= dim_t'(1);
      column_count_r <= dim_t'(1);
      rd_vld_r       <= 1'b0;
      rd_last_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      rd_vld_r   <= issue;
      rd_last_r  <= last;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROW_COUNT:    row_count_r    <= cfg_data;
          CFG_COLUMN_COUNT: column_count_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Sequencer position needs no reset: only used once a run is set up
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    bottom_r   <= bottom_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    run_cols_r <= run_cols_nxt;
  end

  srm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept),
    .waddr(load_cnt_r[ADDR_W-1:0]),
    .wdata(DATA_W'(in_element_value)),
    .re   (issue),
    .raddr(addr_prod[ADDR_W-1:0]),
    .rdata(rdata)
  );

  assign out_valid        = rd_vld_r;
  assign out_spiral_value = $signed(rdata);
  assign out_run_last     = rd_last_r;

endmodule

### design/srm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module srm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/srm_checker.sv
// Port-level checker for the spiral-order matrix reader, with its bind
`include "assert_macros.svh"

module srm_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_run_last
);

  `SRM_ASSERT_CLK(a_strobe_in_busy, clk, rst_n, out_valid |-> busy, "result strobe while idle")
  `SRM_ASSERT_CLK(a_last_has_strobe, clk, rst_n, out_run_last |-> out_valid, "last flag without strobe")
  `SRM_ASSERT_CLK(a_run_contiguous, clk, rst_n, (out_valid && !out_run_last) |=> out_valid, "gap in spiral run")
  `SRM_ASSERT_CLK(a_quiet_after_last, clk, rst_n, out_run_last |=> (!out_valid && !busy), "activity after last result")
  `SRM_ASSERT_CLK(a_busy_ends_on_last, clk, rst_n, $fell(busy) |-> $past(out_run_last), "busy dropped mid-run")

endmodule

bind spiral_order_matrix_reader srm_checker u_srm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .busy        (busy),
  .out_valid   (out_valid),
  .out_run_last(out_run_last)
);
